// ===== hw/rtl/redo_log_transaction_tracker_assert.svh =====
// Assertion helpers for the redo log tracker.
// Both expect clk and rst_n in scope.
`ifndef REDO_LOG_TRANSACTION_TRACKER_ASSERT_SVH
`define REDO_LOG_TRANSACTION_TRACKER_ASSERT_SVH

// same-cycle implication
`define RLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("redo log tracker: assertion failed");

// next-cycle implication
`define RLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("redo log tracker: assertion failed");

`endif

// ===== hw/rtl/rlt_pkg.sv =====
`default_nettype none

package rlt_pkg;

  localparam int LOG_ENTRIES       = 32;
  localparam int BLOCK_NUMBER_BITS = 24;

  localparam int SLOT_W = $clog2(LOG_ENTRIES);
  localparam int CNT_W  = $clog2(LOG_ENTRIES + 1);
  localparam int OPEN_W = 6;
  localparam int LAB_W  = 11;
  localparam int MBP_W  = 6;
  localparam int CFG_W  = LAB_W;
  localparam int NEED_W = OPEN_W + 1 + MBP_W + 1;

  localparam logic [OPEN_W-1:0] OPEN_MAX = '1;

  localparam logic [LAB_W-1:0] LAB_RESET = LAB_W'(31);
  localparam logic [MBP_W-1:0] MBP_RESET = MBP_W'(10);

  // configuration register indexes
  localparam logic CFG_LOG_AREA   = 1'b0;
  localparam logic CFG_MAX_PER_OP = 1'b1;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_END   = 2'd1,
    OP_LOG   = 2'd2,
    OP_DONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_WAIT       = 3'd1,
    STS_FULL       = 3'd2,
    STS_OUTSIDE    = 3'd3,
    STS_END_COMMIT = 3'd4,
    STS_COMMIT     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_RESP
  } state_t;

  // table write port
  typedef struct packed {
    logic                         en;
    logic [SLOT_W-1:0]            addr;
    logic [BLOCK_NUMBER_BITS-1:0] data;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rlt_log_table.sv =====
`default_nettype none

// Logged block table: one write port, one registered read port and the
// block number comparator used by the duplicate scan.
module rlt_log_table (
  input  wire logic                                  clk,
  input  wire rlt_pkg::tbl_wr_t                      wr,
  input  wire logic [rlt_pkg::SLOT_W-1:0]            rd_addr,
  input  wire logic [rlt_pkg::BLOCK_NUMBER_BITS-1:0] key,
  output logic      [rlt_pkg::BLOCK_NUMBER_BITS-1:0] rd_data,
  output logic                                       match
);
  import rlt_pkg::*;

  logic [BLOCK_NUMBER_BITS-1:0] mem [LOG_ENTRIES];
  logic [BLOCK_NUMBER_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign match   = (rd_data_r == key);

endmodule

`default_nettype wire

// ===== hw/rtl/redo_log_transaction_tracker.sv =====
// Flow: begin, end, commit done and rejected log writes pass through ST_DECODE and ST_RESP to
//   out_; an end that starts a group commit emits the table instead, and a log write first
//   scans the table, reading and comparing each entry in turn. in_stall holds off a new item
//   until the tracker is back in ST_IDLE; a commit emits one beat per entry, held by out_stall.
// Reset: synchronous, active low; counters, flags and handshake cleared, config set to 31
//   and 10; table contents are not reset.
`default_nettype none

`include "redo_log_transaction_tracker_assert.svh"

module redo_log_transaction_tracker (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // configuration
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [rlt_pkg::CFG_W-1:0]             cfg_wdata,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            in_opcode,
  input  wire logic [rlt_pkg::BLOCK_NUMBER_BITS-1:0] in_block_number,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [2:0]                                 out_status,
  output logic [rlt_pkg::BLOCK_NUMBER_BITS-1:0]      out_block_number_res,
  output logic [rlt_pkg::SLOT_W-1:0]                 out_slot,
  output logic                                       out_new_entry,
  output logic                                       out_last,
  output logic [rlt_pkg::CNT_W-1:0]                  out_logged_count
);
  import rlt_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [LAB_W-1:0]  log_area_r;
  logic [MBP_W-1:0]  max_per_op_r;

  logic [OPEN_W-1:0] open_r, open_nxt;
  logic              commit_r, commit_nxt;
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;

  // captured input beat
  op_t                          op_r;
  logic [BLOCK_NUMBER_BITS-1:0] blk_r;

  // scan / emit index and number of blocks to emit
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  emit_n_r, emit_n_nxt;

  // pending single result, pushed out from ST_RESP
  status_t                      res_status_r, res_status_nxt;
  logic [BLOCK_NUMBER_BITS-1:0] res_blk_r, res_blk_nxt;
  logic [SLOT_W-1:0]            res_slot_r, res_slot_nxt;
  logic                         res_new_r, res_new_nxt;
  logic [CNT_W-1:0]             res_count_r, res_count_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  status_t                      out_status_r, out_status_nxt;
  logic [BLOCK_NUMBER_BITS-1:0] out_blk_r, out_blk_nxt;
  logic [SLOT_W-1:0]            out_slot_r, out_slot_nxt;
  logic                         out_new_r, out_new_nxt;
  logic                         out_last_r, out_last_nxt;
  logic [CNT_W-1:0]             out_count_r, out_count_nxt;

  // table
  tbl_wr_t                      tbl_wr;
  logic [BLOCK_NUMBER_BITS-1:0] tbl_rd_data;
  logic                         tbl_match;

  rlt_log_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (idx_r),
    .key     (blk_r),
    .rd_data (tbl_rd_data),
    .match   (tbl_match)
  );

  // ---------------------------------------------------------------------------
  // Decode terms, from registered state and the in_valid and out_stall inputs
  // ---------------------------------------------------------------------------
  logic              in_fire;
  logic              out_free;
  logic [OPEN_W:0]   open_inc;
  logic [NEED_W-1:0] need;
  logic              begin_ok;
  logic              log_full;
  logic              open_zero;
  logic              count_zero;
  logic              end_commit;
  logic              scan_last;
  logic              emit_last;

  assign in_fire  = in_valid && !in_stall;
  // output register is empty or its beat leaves this cycle
  assign out_free = !out_valid_r || !out_stall;

  // worst-case reservation: logged + (open + 1) * max_per_op must fit the table
  assign open_inc = {1'b0, open_r} + (OPEN_W + 1)'(1);
  assign need     = NEED_W'(entry_count_r) + NEED_W'(open_inc) * NEED_W'(max_per_op_r);
  assign begin_ok = !commit_r && (open_r != OPEN_MAX) && (need <= NEED_W'(LOG_ENTRIES));

  // table full, or the log area (less its header block) is used up
  assign log_full = (entry_count_r >= CNT_W'(LOG_ENTRIES)) ||
                    ((LAB_W'(entry_count_r) + LAB_W'(1)) >= log_area_r);

  assign open_zero  = (open_r == '0);
  assign count_zero = (entry_count_r == '0);
  // last open operation ends with blocks logged
  assign end_commit = (open_r == OPEN_W'(1)) && !count_zero;

  assign scan_last = ((CNT_W'(idx_r) + CNT_W'(1)) == entry_count_r);
  assign emit_last = ((CNT_W'(idx_r) + CNT_W'(1)) == emit_n_r);

  assign in_stall = (state_r != ST_IDLE);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (op_r)
          OP_BEGIN: state_nxt = ST_RESP;
          OP_END: begin
            if (!commit_r && !open_zero && end_commit) begin
              state_nxt = ST_EMIT_RD;
            end else begin
              state_nxt = ST_RESP;
            end
          end
          OP_LOG: begin
            if (!log_full && !open_zero && !count_zero) begin
              state_nxt = ST_SCAN_RD;
            end else begin
              state_nxt = ST_RESP;
            end
          end
          OP_DONE: state_nxt = ST_RESP;
        endcase
      end
      ST_SCAN_RD:  state_nxt = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (tbl_match || scan_last) begin
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_free) begin
          state_nxt = emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    open_nxt        = open_r;
    commit_nxt      = commit_r;
    entry_count_nxt = entry_count_r;
    idx_nxt         = idx_r;
    emit_n_nxt      = emit_n_r;

    res_status_nxt = res_status_r;
    res_blk_nxt    = res_blk_r;
    res_slot_nxt   = res_slot_r;
    res_new_nxt    = res_new_r;
    res_count_nxt  = res_count_r;

    // beat taken clears the register; a load below sets it again
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;
    out_slot_nxt   = out_slot_r;
    out_new_nxt    = out_new_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;

    tbl_wr.en   = 1'b0;
    tbl_wr.addr = entry_count_r[SLOT_W-1:0];
    tbl_wr.data = blk_r;

    unique case (state_r)
      ST_DECODE: begin
        res_status_nxt = STS_OK;
        res_blk_nxt    = '0;
        res_slot_nxt   = '0;
        res_new_nxt    = 1'b0;
        res_count_nxt  = entry_count_r;
        unique case (op_r)
          OP_BEGIN: begin
            if (begin_ok) begin
              open_nxt = open_r + OPEN_W'(1);
            end else begin
              res_status_nxt = STS_WAIT;
            end
          end
          OP_END: begin
            priority if (commit_r) begin
              res_status_nxt = STS_END_COMMIT;
            end else if (open_zero) begin
              res_status_nxt = STS_OUTSIDE;
            end else begin
              open_nxt = open_r - OPEN_W'(1);
              if (end_commit) begin
                // group commit: hand the table to the emitter, empty the count
                commit_nxt      = 1'b1;
                emit_n_nxt      = entry_count_r;
                entry_count_nxt = '0;
                idx_nxt         = '0;
              end
            end
          end
          OP_LOG: begin
            // full is checked first, even for a block already logged
            priority if (log_full) begin
              res_status_nxt = STS_FULL;
            end else if (open_zero) begin
              res_status_nxt = STS_OUTSIDE;
            end else if (count_zero) begin
              // empty table: append at slot 0 without a scan
              tbl_wr.en       = 1'b1;
              entry_count_nxt = entry_count_r + CNT_W'(1);
              res_blk_nxt     = blk_r;
              res_new_nxt     = 1'b1;
              res_count_nxt   = entry_count_r + CNT_W'(1);
            end else begin
              idx_nxt = '0;
            end
          end
          OP_DONE: begin
            commit_nxt = 1'b0;
          end
        endcase
      end
      ST_SCAN_CMP: begin
        priority if (tbl_match) begin
          // duplicate absorbed
          res_status_nxt = STS_OK;
          res_blk_nxt    = blk_r;
          res_slot_nxt   = idx_r;
          res_new_nxt    = 1'b0;
          res_count_nxt  = entry_count_r;
        end else if (scan_last) begin
          // no match: append at the tail
          tbl_wr.en       = 1'b1;
          entry_count_nxt = entry_count_r + CNT_W'(1);
          res_status_nxt  = STS_OK;
          res_blk_nxt     = blk_r;
          res_slot_nxt    = entry_count_r[SLOT_W-1:0];
          res_new_nxt     = 1'b1;
          res_count_nxt   = entry_count_r + CNT_W'(1);
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STS_COMMIT;
          out_blk_nxt    = tbl_rd_data;
          out_slot_nxt   = idx_r;
          out_new_nxt    = 1'b0;
          out_last_nxt   = emit_last;
          out_count_nxt  = '0;
          if (!emit_last) begin
            idx_nxt = idx_r + SLOT_W'(1);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_blk_nxt    = res_blk_r;
          out_slot_nxt   = res_slot_r;
          out_new_nxt    = res_new_r;
          out_last_nxt   = 1'b1;
          out_count_nxt  = res_count_r;
        end
      end
      ST_IDLE, ST_SCAN_RD, ST_EMIT_RD: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      open_r        <= '0;
      commit_r      <= 1'b0;
      entry_count_r <= '0;
      out_valid_r   <= 1'b0;
      log_area_r    <= LAB_RESET;
      max_per_op_r  <= MBP_RESET;
    end else begin
      state_r       <= state_nxt;
      open_r        <= open_nxt;
      commit_r      <= commit_nxt;
      entry_count_r <= entry_count_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOG_AREA:   log_area_r   <= cfg_wdata;
          CFG_MAX_PER_OP: max_per_op_r <= cfg_wdata[MBP_W-1:0];
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= op_t'(in_opcode);
      blk_r <= in_block_number;
    end
    idx_r        <= idx_nxt;
    emit_n_r     <= emit_n_nxt;
    res_status_r <= res_status_nxt;
    res_blk_r    <= res_blk_nxt;
    res_slot_r   <= res_slot_nxt;
    res_new_r    <= res_new_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_slot_r   <= out_slot_nxt;
    out_new_r    <= out_new_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_block_number_res = out_blk_r;
  assign out_slot             = out_slot_r;
  assign out_new_entry        = out_new_r;
  assign out_last             = out_last_r;
  assign out_logged_count     = out_count_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an accepted beat is always decoded in the following cycle
  `RLT_ASSERT_NXT(a_fire_decodes, in_fire, state_r == ST_DECODE)
  // while emitting, the commit flag is held and the table count is empty
  `RLT_ASSERT_IMP(a_emit_commit, state_r == ST_EMIT_OUT, commit_r && count_zero)
  // a scan only runs inside a transaction with blocks logged
  `RLT_ASSERT_IMP(a_scan_ctx, state_r == ST_SCAN_CMP, !open_zero && !count_zero && !log_full)

endmodule

`default_nettype wire
